>>> sv/token_bucket_shaper_top_macros.svh
// Assertion macros used by the token bucket shaper top level.
`ifndef TOKEN_BUCKET_SHAPER_TOP_MACROS_SVH
`define TOKEN_BUCKET_SHAPER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBS_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("token bucket shaper: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBS_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("token bucket shaper: next-cycle check failed");

`endif

>>> sv/tbs_pkg.sv
// Types, constants and control codes of the token bucket shaper.
package tbs_pkg;

	// Reset values of the configuration registers
	localparam logic [15:0] CAP_RESET  = 16'd500;
	localparam logic [23:0] RATE_RESET = 24'd256;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd1;

	// One quotient bit per divider step
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [31:0] arrive_stamp;
		logic [31:0] packet_tag;
		logic [15:0] packet_bytes;
	} pkt_item_t;

	typedef struct packed {
		logic [31:0] depart_time;
		logic [31:0] out_tag;
		logic [15:0] out_bytes;
		logic        was_delayed;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_EARN,
		ST_SPEND,
		ST_DIV,
		ST_SUM,
		ST_FINISH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic earn;
		logic spend;
		logic div_step;
		logic sum;
		logic emit;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic short_tokens;
	} status_t;

endpackage

>>> sv/token_bucket_shaper_top.sv
// Token bucket shaper: paces packets by a refill rate and a bucket capacity.
//
// Packets enter on pkt (pkt_valid / pkt_stall) with arrival time, tag and size;
// each leaves one result on res (res_valid / res_stall) with its departure
// time, tag, size and a flag telling whether it had to wait for tokens.
// Times are unsigned 24.8 seconds; the refill rate is 16.8 tokens per second.
// Configuration: cfg_wen writes cfg_data into register cfg_index
// (0 = bucket capacity, which also refills the bucket; 1 = refill rate).
// One packet is processed at a time. A packet with enough tokens passes
// the multiply, earn, spend and finish states; a packet short of tokens
// also passes the divide and sum states, as the wait time comes from a divider
// retiring one quotient bit a cycle. The next packet is accepted in the
// cycle after a result is loaded into the output register.
// A result held by res_stall stays in the output register; the block still
// accepts and works on the next packet and holds its result until the
// register frees up.
// Reset: capacity 500, rate 1.0, bucket full, last departure zero; no result.
module token_bucket_shaper_top
	import tbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]          cfg_data,
	input  logic                 pkt_valid,
	output logic                 pkt_stall,
	input  pkt_item_t            pkt,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_item_t            res
);

`include "token_bucket_shaper_top_macros.svh"

	cmd_t    cmd;
	status_t status;

	tbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tbs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt       (pkt),
		.cmd       (cmd),
		.status    (status),
		.res       (res)
	);

	// One packet at a time: an accepted packet blocks the input next cycle
	`TBS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, pkt_valid && !pkt_stall, pkt_stall)
	// A new result never overwrites one still held by the receiver
	`TBS_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.emit, !res_valid || !res_stall)
	// Results appear only after the controller loaded one
	`TBS_ASSERT_NOW(a_valid_from_emit, clk, arst_n, $rose(res_valid), $past(cmd.emit))

endmodule

>>> sv/tbs_ctrl.sv
// Controller state machine of the token bucket shaper.
module tbs_ctrl
	import tbs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pkt_valid,
	output logic    pkt_stall,
	output logic    res_valid,
	input  logic    res_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t               state_q, state_nxt;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 res_valid_q;
	logic                 out_free;

	// Output register can take a new result this cycle
	assign out_free = !res_valid_q || !res_stall;

	// State register, divider step counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.spend) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pkt_valid) state_nxt = ST_MUL;
			end
			ST_MUL:   state_nxt = ST_EARN;
			ST_EARN:  state_nxt = ST_SPEND;
			ST_SPEND: begin
				state_nxt = status.short_tokens ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_SUM;
			end
			ST_SUM: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Commands and handshake outputs
	always_comb begin
		cmd          = '0;
		pkt_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				pkt_stall = 1'b0;
				cmd.load  = pkt_valid;
			end
			ST_MUL:    cmd.mul      = 1'b1;
			ST_EARN:   cmd.earn     = 1'b1;
			ST_SPEND:  cmd.spend    = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_SUM:    cmd.sum      = 1'b1;
			ST_FINISH: cmd.emit     = out_free;
			default:   cmd          = '0;
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

>>> sv/tbs_datapath.sv
// Datapath of the token bucket shaper: bucket state, refill multiply, wait divider.
module tbs_datapath
	import tbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]          cfg_data,
	input  pkt_item_t            pkt,
	input  cmd_t                 cmd,
	output status_t              status,
	output res_item_t            res
);

	// Configuration and bucket state
	logic [15:0] cap_q;
	logic [23:0] rate_q;
	logic [15:0] token_q;
	logic [31:0] last_q;

	// Current item and work registers
	pkt_item_t   item_q;
	logic        later_q;
	logic [39:0] earned_q;
	logic        delayed_q;
	logic [23:0] rem_q;
	logic [31:0] quo_q;
	res_item_t   res_q;

	logic [31:0] elapsed;
	logic [55:0] prod;
	logic [16:0] sum17;
	logic [15:0] earn_val;
	logic        short_tokens;
	logic [15:0] deficit;
	logic [24:0] shifted;
	logic [25:0] diff;
	logic        ge;
	logic [31:0] wait_time;
	logic [32:0] when33;

	// Refill: rate times elapsed time, 16 fraction bits dropped
	assign elapsed = item_q.arrive_stamp - last_q;
	assign prod    = {32'b0, rate_q} * {24'b0, elapsed};

	// Capped token sum
	assign sum17    = {1'b0, token_q} + {1'b0, earned_q[15:0]};
	assign earn_val = ((|earned_q[39:16]) || (sum17 > {1'b0, cap_q})) ? cap_q : sum17[15:0];

	assign short_tokens = token_q < item_q.packet_bytes;
	assign deficit      = item_q.packet_bytes - token_q;

	// One restoring division step
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = {1'b0, shifted} - {2'b0, rate_q};
	assign ge      = !diff[25];

	// Saturating departure time; zero rate waits forever
	assign wait_time = (rate_q == '0) ? '1 : quo_q;
	assign when33    = {1'b0, last_q} + {1'b0, wait_time};

	// Registers with reset: configuration and bucket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			rate_q  <= RATE_RESET;
			token_q <= CAP_RESET;
			last_q  <= '0;
		end else begin
			if (cfg_wen && (cfg_index == CFG_CAPACITY)) begin
				cap_q   <= cfg_data[15:0];
				token_q <= cfg_data[15:0];
			end else if (cfg_wen && (cfg_index == CFG_RATE)) begin
				rate_q <= cfg_data;
			end else if (cmd.earn && later_q) begin
				token_q <= earn_val;
				last_q  <= item_q.arrive_stamp;
			end else if (cmd.spend) begin
				token_q <= short_tokens ? '0 : token_q - item_q.packet_bytes;
			end else if (cmd.sum) begin
				last_q <= when33[32] ? '1 : when33[31:0];
			end
		end
	end

	// Payload and work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= pkt;
		end
		if (cmd.mul) begin
			later_q  <= item_q.arrive_stamp > last_q;
			earned_q <= prod[55:16];
		end
		if (cmd.spend) begin
			delayed_q <= short_tokens;
			rem_q     <= '0;
			quo_q     <= {deficit, 16'b0};
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[23:0] : shifted[23:0];
			quo_q <= {quo_q[30:0], ge};
		end
		if (cmd.emit) begin
			res_q.depart_time <= last_q;
			res_q.out_tag     <= item_q.packet_tag;
			res_q.out_bytes   <= item_q.packet_bytes;
			res_q.was_delayed <= delayed_q;
		end
	end

	assign status.short_tokens = short_tokens;
	assign res                 = res_q;

endmodule
